// ----- rtl/rgb_to_hsv_fixed_core_defines.svh -----
// Assertion macros for the RGB to HSV core checker.
// Expects clk and arst_n in the scope of each use.
`ifndef RGB_TO_HSV_FIXED_CORE_DEFINES_SVH
`define RGB_TO_HSV_FIXED_CORE_DEFINES_SVH

// clocked property, disabled in reset
`define HSV_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
	else $error("%m: hsv check failed");

// implication form
`define HSV_ASSERT_IMP(label, ante, cons) \
	`HSV_ASSERT(label, (ante) |-> (cons))

`endif

// ----- rtl/hsv_pkg.sv -----
// Shared types, widths and constant tables for the RGB to HSV core.
// No dependencies.
`default_nettype none
package hsv_pkg;
	localparam int CH_W   = 8;
	localparam int Q_W    = 16;
	localparam int NUM_W  = CH_W + Q_W;
	localparam int HUE_W  = 9;
	localparam int PCT_W  = 7;
	localparam int SIX_W  = 22;
	localparam int TAB_N  = 1 << CH_W;

	localparam int THIRD_FIX      = (1 << Q_W) / 3;
	localparam int TWO_THIRDS_FIX = (2 << Q_W) / 3;
	localparam int DEG_FULL       = 360;
	localparam int PCT_FULL       = 100;

	typedef enum logic [1:0] {
		SEL_RED,
		SEL_GREEN,
		SEL_BLUE
	} sel_t;

	typedef struct packed {
		sel_t             sel;
		logic             grey;
		logic [PCT_W-1:0] bright;
	} side_t;

	typedef logic [PCT_W-1:0] vtab_t [TAB_N];
	typedef logic [SIX_W-1:0] sixtab_t [TAB_N];

	// percent of full scale for each max channel value
	function automatic vtab_t v_table();
		vtab_t t;
		for (int i = 0; i < TAB_N; i++) begin
			t[i] = PCT_W'(((((i << Q_W) / 255) * PCT_FULL) >> Q_W));
		end
		return t;
	endfunction

	// (d << 16) / 6
	function automatic sixtab_t six_table();
		sixtab_t t;
		for (int i = 0; i < TAB_N; i++) begin
			t[i] = SIX_W'(((i << Q_W) / 6));
		end
		return t;
	endfunction
endpackage
`default_nettype wire

// ----- rtl/hsv_prep.sv -----
// Front stages: max/min/delta, channel select, numerators and divisors.
// Depends on hsv_pkg.
`default_nettype none
module hsv_prep (
	input  wire                              clk,
	input  wire                              en,
	input  wire  [hsv_pkg::CH_W-1:0]         red,
	input  wire  [hsv_pkg::CH_W-1:0]         green,
	input  wire  [hsv_pkg::CH_W-1:0]         blue,
	output logic [hsv_pkg::NUM_W-1:0]        num_r_s2,
	output logic [hsv_pkg::NUM_W-1:0]        num_g_s2,
	output logic [hsv_pkg::NUM_W-1:0]        num_b_s2,
	output logic [hsv_pkg::NUM_W-1:0]        num_s_s2,
	output logic [hsv_pkg::CH_W-1:0]         den_h_s2,
	output logic [hsv_pkg::CH_W-1:0]         den_s_s2,
	output hsv_pkg::side_t                   side_s2
);
	localparam hsv_pkg::vtab_t   V_TAB   = hsv_pkg::v_table();
	localparam hsv_pkg::sixtab_t SIX_TAB = hsv_pkg::six_table();
	localparam int SH = hsv_pkg::Q_W - 1;

	logic [hsv_pkg::CH_W-1:0] mx, mn;
	hsv_pkg::sel_t sel;
	logic [hsv_pkg::CH_W-1:0] r_s1, g_s1, b_s1, mx_s1, dl_s1;
	hsv_pkg::sel_t sel_s1;

	always_comb begin
		mx = red;
		if (green > mx) mx = green;
		if (blue > mx) mx = blue;
		mn = red;
		if (green < mn) mn = green;
		if (blue < mn) mn = blue;
		if (red == mx) sel = hsv_pkg::SEL_RED;
		else if (green == mx) sel = hsv_pkg::SEL_GREEN;
		else sel = hsv_pkg::SEL_BLUE;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r_s1   <= red;
			g_s1   <= green;
			b_s1   <= blue;
			mx_s1  <= mx;
			dl_s1  <= mx - mn;
			sel_s1 <= sel;
		end
	end

	logic [hsv_pkg::NUM_W-1:0] half;
	logic grey;
	assign half = {1'b0, dl_s1, {SH{1'b0}}};
	assign grey = (dl_s1 == '0);

	always_ff @(posedge clk) begin
		if (en) begin
			num_r_s2 <= hsv_pkg::NUM_W'(SIX_TAB[mx_s1 - r_s1]) + half;
			num_g_s2 <= hsv_pkg::NUM_W'(SIX_TAB[mx_s1 - g_s1]) + half;
			num_b_s2 <= hsv_pkg::NUM_W'(SIX_TAB[mx_s1 - b_s1]) + half;
			num_s_s2 <= {dl_s1, {hsv_pkg::Q_W{1'b0}}};
			den_h_s2 <= grey ? hsv_pkg::CH_W'(1) : dl_s1;
			den_s_s2 <= (mx_s1 == '0) ? hsv_pkg::CH_W'(1) : mx_s1;
			side_s2  <= '{sel: sel_s1, grey: grey, bright: V_TAB[mx_s1]};
		end
	end
endmodule
`default_nettype wire

// ----- rtl/hsv_div.sv -----
// Pipelined restoring divider, one quotient bit per stage.
// Quotient must fit in Q_W bits (num >> Q_W below den). Depends on hsv_pkg.
`default_nettype none
module hsv_div (
	input  wire                         clk,
	input  wire                         en,
	input  wire  [hsv_pkg::NUM_W-1:0]   num,
	input  wire  [hsv_pkg::CH_W-1:0]    den,
	output logic [hsv_pkg::Q_W-1:0]     quo
);
	localparam int N = hsv_pkg::Q_W;
	localparam int W = hsv_pkg::CH_W;

	logic [W-1:0] rem_s [N+1];
	logic [N-1:0] low_s [N+1];
	logic [N-1:0] q_s   [N+1];
	logic [W-1:0] den_s [N+1];

	assign rem_s[0] = num[hsv_pkg::NUM_W-1:N];
	assign low_s[0] = num[N-1:0];
	assign q_s[0]   = '0;
	assign den_s[0] = den;

	for (genvar k = 0; k < N; k++) begin : g_step
		logic [W:0] trial;
		logic       ge;
		assign trial = {rem_s[k], low_s[k][N-1]};
		assign ge    = (trial >= {1'b0, den_s[k]});
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= ge ? W'(trial - {1'b0, den_s[k]}) : trial[W-1:0];
				low_s[k+1] <= {low_s[k][N-2:0], 1'b0};
				q_s[k+1]   <= {q_s[k][N-2:0], ge};
				den_s[k+1] <= den_s[k];
			end
		end
	end

	assign quo = q_s[N];
endmodule
`default_nettype wire

// ----- rtl/hsv_post.sv -----
// Back stages: hue difference and scaling, percent scaling, wrap, output regs.
// Depends on hsv_pkg.
`default_nettype none
module hsv_post (
	input  wire                          clk,
	input  wire                          en,
	input  wire  [hsv_pkg::Q_W-1:0]      q_r,
	input  wire  [hsv_pkg::Q_W-1:0]      q_g,
	input  wire  [hsv_pkg::Q_W-1:0]      q_b,
	input  wire  [hsv_pkg::Q_W-1:0]      q_s,
	input  hsv_pkg::side_t               side,
	output logic [hsv_pkg::HUE_W-1:0]    hue_s2,
	output logic [hsv_pkg::PCT_W-1:0]    sat_s2,
	output logic [hsv_pkg::PCT_W-1:0]    bright_s2
);
	localparam int DW = hsv_pkg::Q_W + 2;
	localparam int PW = DW + 9;
	localparam int SW = hsv_pkg::Q_W + 7;
	localparam int HW = PW - hsv_pkg::Q_W;

	logic signed [DW-1:0] ar, ag, ab, diff;
	assign ar = signed'(DW'(q_r));
	assign ag = signed'(DW'(q_g));
	assign ab = signed'(DW'(q_b));

	always_comb begin
		case (side.sel)
			hsv_pkg::SEL_RED:   diff = ab - ag;
			hsv_pkg::SEL_GREEN: diff = ar - ab + DW'(hsv_pkg::THIRD_FIX);
			default:            diff = ag - ar + DW'(hsv_pkg::TWO_THIRDS_FIX);
		endcase
	end

	logic signed [PW-1:0] prod_s1;
	logic [SW-1:0]        satp_s1;
	hsv_pkg::side_t       side_s1;

	// delta equal to max makes the quotient 1.0, which saturates the divider
	// to all ones; no other pixel reaches all ones
	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= PW'(diff) * signed'(PW'(hsv_pkg::DEG_FULL));
			satp_s1 <= (&q_s) ? SW'(hsv_pkg::PCT_FULL << hsv_pkg::Q_W)
				: SW'(q_s) * SW'(hsv_pkg::PCT_FULL);
			side_s1 <= side;
		end
	end

	logic signed [HW-1:0] h, hw;
	assign h = prod_s1[PW-1:hsv_pkg::Q_W];

	always_comb begin
		if (h < 0) hw = h + HW'(hsv_pkg::DEG_FULL);
		else if (h > HW'(hsv_pkg::DEG_FULL)) hw = h - HW'(hsv_pkg::DEG_FULL);
		else hw = h;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hue_s2    <= side_s1.grey ? '0 : hw[hsv_pkg::HUE_W-1:0];
			sat_s2    <= side_s1.grey ? '0 : satp_s1[hsv_pkg::Q_W +: hsv_pkg::PCT_W];
			bright_s2 <= side_s1.bright;
		end
	end
endmodule
`default_nettype wire

// ----- rtl/rgb_to_hsv_fixed_core.sv -----
// RGB to HSV converter, top level. Depends on hsv_pkg, hsv_prep, hsv_div,
// hsv_post.
//
// Converts one 8-bit RGB pixel per clock to hue (0..360 degrees), saturation
// and value (0..100 percent). Fully pipelined: a pixel may enter every cycle
// and its result passes through 2 front stages, 16 divider stages (one
// quotient bit each) and 2 back stages. Back pressure stalls the whole
// pipeline; s_tready drops only while the output holds a result not taken.
`default_nettype none
module rgb_to_hsv_fixed_core (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [23:0] s_tdata,   // red[7:0], green[15:8], blue[23:16]
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [23:0] m_tdata    // hue[8:0], saturation[15:9], brightness[22:16]
);
	localparam int DEPTH = hsv_pkg::Q_W + 4;
	localparam int W = hsv_pkg::CH_W;

	logic en;
	logic [DEPTH-1:0] vld_q;

	assign en       = !vld_q[DEPTH-1] || m_tready;
	assign s_tready = en;
	assign m_tvalid = vld_q[DEPTH-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[DEPTH-2:0], s_tvalid};
		end
	end

	logic [hsv_pkg::NUM_W-1:0] num_r, num_g, num_b, num_s;
	logic [W-1:0] den_h, den_s;
	hsv_pkg::side_t side;

	hsv_prep u_prep (
		.clk      (clk),
		.en       (en),
		.red      (s_tdata[W-1:0]),
		.green    (s_tdata[2*W-1:W]),
		.blue     (s_tdata[3*W-1:2*W]),
		.num_r_s2 (num_r),
		.num_g_s2 (num_g),
		.num_b_s2 (num_b),
		.num_s_s2 (num_s),
		.den_h_s2 (den_h),
		.den_s_s2 (den_s),
		.side_s2  (side)
	);

	logic [hsv_pkg::Q_W-1:0] q_r, q_g, q_b, q_s;

	hsv_div u_div_r (.clk(clk), .en(en), .num(num_r), .den(den_h), .quo(q_r));
	hsv_div u_div_g (.clk(clk), .en(en), .num(num_g), .den(den_h), .quo(q_g));
	hsv_div u_div_b (.clk(clk), .en(en), .num(num_b), .den(den_h), .quo(q_b));
	hsv_div u_div_s (.clk(clk), .en(en), .num(num_s), .den(den_s), .quo(q_s));

	hsv_pkg::side_t side_s [hsv_pkg::Q_W+1];
	assign side_s[0] = side;
	for (genvar k = 0; k < hsv_pkg::Q_W; k++) begin : g_side
		always_ff @(posedge clk) begin
			if (en) side_s[k+1] <= side_s[k];
		end
	end

	logic [hsv_pkg::HUE_W-1:0] hue;
	logic [hsv_pkg::PCT_W-1:0] sat, bright;

	hsv_post u_post (
		.clk       (clk),
		.en        (en),
		.q_r       (q_r),
		.q_g       (q_g),
		.q_b       (q_b),
		.q_s       (q_s),
		.side      (side_s[hsv_pkg::Q_W]),
		.hue_s2    (hue),
		.sat_s2    (sat),
		.bright_s2 (bright)
	);

	assign m_tdata = {1'b0, bright, sat, hue};
endmodule
`default_nettype wire

// ----- rtl/hsv_chk.sv -----
// Port-level checker for the RGB to HSV core, bound to the top level.
// Depends on rgb_to_hsv_fixed_core_defines.svh.
`default_nettype none
`include "rgb_to_hsv_fixed_core_defines.svh"
module hsv_chk (
	input wire        clk,
	input wire        arst_n,
	input wire        s_tready,
	input wire        m_tvalid,
	input wire        m_tready,
	input wire [23:0] m_tdata
);
	`HSV_ASSERT_IMP(a_hue_range, m_tvalid, m_tdata[8:0] <= 9'd360)
	`HSV_ASSERT_IMP(a_pct_range, m_tvalid, m_tdata[15:9] <= 7'd100 && m_tdata[22:16] <= 7'd100)
	`HSV_ASSERT_IMP(a_ready_free, !m_tvalid, s_tready)
	`HSV_ASSERT_IMP(a_hold, m_tvalid && !m_tready, ##1 m_tvalid && $stable(m_tdata))
endmodule

bind rgb_to_hsv_fixed_core hsv_chk u_hsv_chk (.*);
`default_nettype wire
